// ===== sv/bte_pkg.sv =====
// Shared types and constants of the beat tempo estimator.
package bte_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;

  localparam int IN_W  = 80;
  localparam int OUT_W = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 24;

  localparam logic [16:0] LOW_LEVEL_LIMIT = 17'd656;
  localparam logic [16:0] ONE_Q16         = 17'd65536;
  localparam logic [20:0] TEMPO_NUM       = 21'd1920000;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_FLOOR = 3'd6;

  localparam logic [12:0] RST_MIN_TEMPO  = 13'd960;
  localparam logic [12:0] RST_MAX_TEMPO  = 13'd3200;
  localparam logic [16:0] RST_BASE_THR   = 17'd32768;
  localparam logic [15:0] RST_DECAY      = 16'd58982;
  localparam logic [15:0] RST_MIN_GAP    = 16'd300;
  localparam logic [15:0] RST_MAX_GAP    = 16'd2000;
  localparam logic [16:0] RST_CONF_FLOOR = 17'd32768;

  typedef enum logic [1:0] {
    ST_DETECT  = 2'd0,
    ST_LOWCONF = 2'd1,
    ST_NOBEATS = 2'd2,
    ST_LOWSIG  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ENV_A, S_ENV_B, S_ENV_C, S_THR, S_CMP,
    S_GRD, S_GUSE, S_GEND, S_MED1, S_MED2,
    S_TLO, S_THI, S_TCHK, S_DIV,
    S_C1, S_C2, S_C3, S_CDIV, S_SQRT, S_FIN
  } state_t;

endpackage

// ===== sv/beat_tempo_estimator_core.sv =====
// Beat tempo estimator: envelope beat detector with median-interval tempo and confidence.
// Low-signal frames go straight to the result; with under two beats only the envelope, threshold and
//   beat check run; otherwise each stored beat is walked, then the tempo divide and confidence steps.
// Throughput: one frame at a time through one shared 40x24 multiplier; the next frame is taken
//   in the cycle after the result is loaded into the output register.
// Reset (rst, synchronous) clears envelopes, beat count, handshake, loads defaults; not history.
module beat_tempo_estimator_core #(
  parameter int HISTORY_DEPTH = bte_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // bass[23:0], level[40:24], time_ms[72:41], zero pad
  input  logic [bte_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tempo[12:0], confidence[29:13], status[31:30], beat_seen[32], zero pad
  output logic [bte_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [bte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bte_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(HISTORY_DEPTH + 1);   // beat count
  localparam int PW  = $clog2(HISTORY_DEPTH);       // history pointer
  localparam int NW  = $clog2(HISTORY_DEPTH);       // valid interval count
  localparam int IW  = $clog2(HISTORY_DEPTH - 1);   // sorted array index
  localparam int SW  = 16 + NW;                     // interval sum
  localparam int QW  = 32 + NW;                     // sum of squares
  localparam int S2W = 2 * SW;                      // squared sum, variance term
  localparam int RW  = S2W + 1;                     // divider remainder

  // configuration registers
  logic [12:0] min_tempo, max_tempo;
  logic [16:0] base_thr, conf_floor;
  logic [15:0] decay, min_gap, max_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_tempo  <= bte_pkg::RST_MIN_TEMPO;
      max_tempo  <= bte_pkg::RST_MAX_TEMPO;
      base_thr   <= bte_pkg::RST_BASE_THR;
      decay      <= bte_pkg::RST_DECAY;
      min_gap    <= bte_pkg::RST_MIN_GAP;
      max_gap    <= bte_pkg::RST_MAX_GAP;
      conf_floor <= bte_pkg::RST_CONF_FLOOR;
    end else if (cfg_we) begin
      case (cfg_index)
        bte_pkg::CFG_MIN_TEMPO:  min_tempo  <= cfg_data[12:0];
        bte_pkg::CFG_MAX_TEMPO:  max_tempo  <= cfg_data[12:0];
        bte_pkg::CFG_BASE_THR:   base_thr   <= cfg_data;
        bte_pkg::CFG_DECAY:      decay      <= cfg_data[15:0];
        bte_pkg::CFG_MIN_GAP:    min_gap    <= cfg_data[15:0];
        bte_pkg::CFG_MAX_GAP:    max_gap    <= cfg_data[15:0];
        bte_pkg::CFG_CONF_FLOOR: conf_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  bte_pkg::state_t state, state_next;

  // frame payload
  logic [23:0] bass;
  logic [16:0] level;
  logic [31:0] t_r;

  // detector state
  logic [23:0] env, prev_env;
  logic [CW-1:0] cnt;
  logic [PW-1:0] wr_ptr, rp;
  logic [31:0] last_beat, prev_t;
  logic [31:0] hist [HISTORY_DEPTH];
  logic [31:0] hist_q;
  logic [CW-1:0] k;

  // interval statistics
  logic [15:0] srt [HISTORY_DEPTH-1];
  logic [NW-1:0] n;
  logic [SW-1:0] s_sum;
  logic [QW-1:0] q_sum;
  logic sq_pend;
  logic [16:0] med_a, m2;

  // arithmetic
  logic [bte_pkg::MUL_A_W-1:0] mul_a;
  logic [bte_pkg::MUL_B_W-1:0] mul_b;
  logic [bte_pkg::MUL_A_W+bte_pkg::MUL_B_W-1:0] prod;
  logic [40:0] acc;
  logic [20:0] dq;
  logic [16:0] drem;
  logic [S2W-1:0] s2;
  logic [RW-1:0] crem;
  logic [33:0] quo;
  logic [31:0] sx, sr, sbit;
  logic [5:0] it;

  // result
  logic [12:0] tempo;
  logic [16:0] conf;
  logic low_sig, beat_r;

  // ---------------------------------------------------------------- combinational helpers
  logic [16:0] lv;
  logic [34:0] thr;
  logic above, was_above, beat_now;
  logic [31:0] gap;
  logic [CW-1:0] cnt_new;
  logic [PW-1:0] wr_new, oldest_new;
  logic [31:0] d;
  logic d_ok;
  logic [IW-1:0] mi, srt_idx;
  logic [15:0] srt_rd;
  logic [15:0] srt_ins [HISTORY_DEPTH-1];
  logic [HISTORY_DEPTH-2:0] gt;
  logic [41:0] env_sum;
  logic [17:0] drs;
  logic dq_bit;
  logic [20:0] dq_next;
  logic [RW-1:0] crs;
  logic [S2W-1:0] v;
  logic [33:0] quo_next;
  logic [32:0] sq_try;
  logic [31:0] sx_next, sr_next;
  logic in_acc, low_in, out_load;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign low_in  = s_axis_tdata[40:24] < bte_pkg::LOW_LEVEL_LIMIT;
  assign out_load = (state == bte_pkg::S_FIN) && (!m_axis_tvalid || m_axis_tready);

  assign lv        = (level > bte_pkg::ONE_Q16) ? bte_pkg::ONE_Q16 : level;
  assign thr       = prod[34:0];
  assign above     = {env, 17'b0} > {6'b0, thr};
  assign was_above = {prev_env, 17'b0} > {6'b0, thr};
  assign gap       = t_r - last_beat;
  assign beat_now  = above && !was_above && (cnt == '0 || gap >= {16'b0, min_gap});
  assign wr_new    = (wr_ptr == PW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign cnt_new   = (beat_now && cnt != CW'(HISTORY_DEPTH)) ? cnt + 1'b1 : cnt;
  // once full, the oldest entry sits where the next write goes
  assign oldest_new = (cnt_new == CW'(HISTORY_DEPTH)) ? (beat_now ? wr_new : wr_ptr) : '0;

  assign d    = hist_q - prev_t;
  assign d_ok = (k >= CW'(2)) && d >= {16'b0, min_gap} && d <= {16'b0, max_gap};

  // stable insertion into the sorted interval list
  always_comb begin
    for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
      gt[j] = (NW'(j) < n) && (srt[j] > d[15:0]);
    end
    for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
      if (NW'(j) < n && !gt[j]) begin
        srt_ins[j] = srt[j];
      end else if (j == 0) begin
        srt_ins[j] = d[15:0];
      end else if (NW'(j - 1) < n && !gt[j-1]) begin
        srt_ins[j] = d[15:0];
      end else begin
        srt_ins[j] = srt[j-1];
      end
    end
  end

  assign mi      = IW'(n >> 1);
  assign srt_idx = (state == bte_pkg::S_MED1) ? mi : mi - 1'b1;
  assign srt_rd  = srt[srt_idx];

  assign env_sum = {1'b0, acc} + {1'b0, prod[40:0]} + 42'd32768;

  assign drs     = {drem, dq[20]};
  assign dq_bit  = drs >= {1'b0, m2};
  assign dq_next = {dq[19:0], dq_bit};

  assign v        = prod[S2W-1:0] - s2;
  assign crs      = {crem[RW-2:0], 1'b0};
  assign quo_next = {quo[32:0], crs >= RW'(s2)};

  assign sq_try  = {1'b0, sr} + {1'b0, sbit};
  assign sx_next = ({1'b0, sx} >= sq_try) ? sx - sq_try[31:0] : sx;
  assign sr_next = ({1'b0, sx} >= sq_try) ? (sr >> 1) + sbit : (sr >> 1);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      bte_pkg::S_IDLE:  if (in_acc) state_next = low_in ? bte_pkg::S_FIN : bte_pkg::S_ENV_A;
      bte_pkg::S_ENV_A: state_next = (bass > env) ? bte_pkg::S_THR : bte_pkg::S_ENV_B;
      bte_pkg::S_ENV_B: state_next = bte_pkg::S_ENV_C;
      bte_pkg::S_ENV_C: state_next = bte_pkg::S_THR;
      bte_pkg::S_THR:   state_next = bte_pkg::S_CMP;
      bte_pkg::S_CMP:   state_next = (cnt_new >= CW'(2)) ? bte_pkg::S_GRD : bte_pkg::S_FIN;
      bte_pkg::S_GRD:   state_next = bte_pkg::S_GUSE;
      bte_pkg::S_GUSE:  state_next = (k == cnt) ? bte_pkg::S_GEND : bte_pkg::S_GRD;
      bte_pkg::S_GEND:  state_next = (n != '0) ? bte_pkg::S_MED1 : bte_pkg::S_FIN;
      bte_pkg::S_MED1:  state_next = bte_pkg::S_MED2;
      bte_pkg::S_MED2:  state_next = bte_pkg::S_TLO;
      bte_pkg::S_TLO: begin
        if (m2 == '0) state_next = (cnt >= CW'(3)) ? bte_pkg::S_C1 : bte_pkg::S_FIN;
        else state_next = bte_pkg::S_THI;
      end
      bte_pkg::S_THI: begin
        if ({43'b0, bte_pkg::TEMPO_NUM} < prod)
          state_next = (cnt >= CW'(3)) ? bte_pkg::S_C1 : bte_pkg::S_FIN;
        else state_next = bte_pkg::S_TCHK;
      end
      bte_pkg::S_TCHK: begin
        if ({43'b0, bte_pkg::TEMPO_NUM} > prod)
          state_next = (cnt >= CW'(3)) ? bte_pkg::S_C1 : bte_pkg::S_FIN;
        else state_next = bte_pkg::S_DIV;
      end
      bte_pkg::S_DIV: begin
        if (it == 6'd20) state_next = (cnt >= CW'(3)) ? bte_pkg::S_C1 : bte_pkg::S_FIN;
      end
      bte_pkg::S_C1: state_next = ({{(SW-NW){1'b0}}, n} > s_sum) ? bte_pkg::S_FIN : bte_pkg::S_C2;
      bte_pkg::S_C2: state_next = bte_pkg::S_C3;
      bte_pkg::S_C3: state_next = ({v, 2'b0} >= {2'b0, s2}) ? bte_pkg::S_FIN : bte_pkg::S_CDIV;
      bte_pkg::S_CDIV: if (it == 6'd33) state_next = bte_pkg::S_SQRT;
      bte_pkg::S_SQRT: if (it == 6'd15) state_next = bte_pkg::S_FIN;
      bte_pkg::S_FIN:  if (out_load) state_next = bte_pkg::S_IDLE;
      default: state_next = bte_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs and multiplier operands
  always_comb begin
    s_axis_tready = (state == bte_pkg::S_IDLE);
    mul_a = '0;
    mul_b = '0;
    case (state)
      bte_pkg::S_ENV_A: begin
        mul_a = 40'(env);
        mul_b = 24'(decay);
      end
      bte_pkg::S_ENV_B: begin
        mul_a = 40'(bass);
        mul_b = 24'(bte_pkg::ONE_Q16 - {1'b0, decay});
      end
      bte_pkg::S_THR: begin
        mul_a = 40'(base_thr);
        mul_b = 24'({1'b0, bte_pkg::ONE_Q16} + {1'b0, lv});
      end
      bte_pkg::S_GUSE: begin
        mul_a = 40'(d[15:0]);
        mul_b = 24'(d[15:0]);
      end
      bte_pkg::S_TLO: begin
        mul_a = 40'(min_tempo);
        mul_b = 24'(m2);
      end
      bte_pkg::S_THI: begin
        mul_a = 40'(max_tempo);
        mul_b = 24'(m2);
      end
      bte_pkg::S_C1: begin
        mul_a = 40'(s_sum);
        mul_b = 24'(s_sum);
      end
      bte_pkg::S_C2: begin
        mul_a = 40'(q_sum);
        mul_b = 24'(n);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == bte_pkg::S_CMP && beat_now) hist[wr_ptr] <= t_r;
    if (state == bte_pkg::S_GRD) hist_q <= hist[rp];
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bte_pkg::S_IDLE;
      env      <= '0;
      prev_env <= '0;
      cnt      <= '0;
      wr_ptr   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        bte_pkg::S_ENV_A: if (bass > env) env <= bass;
        bte_pkg::S_ENV_C: env <= env_sum[39:16];
        bte_pkg::S_CMP: begin
          prev_env <= env;
          cnt <= cnt_new;
          if (beat_now) wr_ptr <= wr_new;
        end
        default: ;
      endcase
      // hold a finished beat until taken
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      bte_pkg::S_IDLE: begin
        bass    <= s_axis_tdata[23:0];
        level   <= s_axis_tdata[40:24];
        t_r     <= s_axis_tdata[72:41];
        low_sig <= low_in;
        beat_r  <= 1'b0;
        tempo   <= '0;
        conf    <= '0;
        n       <= '0;
        s_sum   <= '0;
        q_sum   <= '0;
        sq_pend <= 1'b0;
      end
      bte_pkg::S_ENV_B: acc <= prod[40:0];
      bte_pkg::S_CMP: begin
        if (beat_now) begin
          last_beat <= t_r;
          beat_r    <= 1'b1;
        end
        rp <= oldest_new;
        k  <= '0;
      end
      bte_pkg::S_GRD: begin
        rp <= (rp == PW'(HISTORY_DEPTH - 1)) ? '0 : rp + 1'b1;
        k  <= k + 1'b1;
        if (sq_pend) q_sum <= q_sum + QW'(prod[31:0]);
        sq_pend <= 1'b0;
      end
      bte_pkg::S_GUSE: begin
        prev_t <= hist_q;
        if (d_ok) begin
          for (int j = 0; j < HISTORY_DEPTH - 1; j++) srt[j] <= srt_ins[j];
          n       <= n + 1'b1;
          s_sum   <= s_sum + SW'(d[15:0]);
          sq_pend <= 1'b1;
        end
      end
      bte_pkg::S_GEND: begin
        if (sq_pend) q_sum <= q_sum + QW'(prod[31:0]);
        sq_pend <= 1'b0;
      end
      bte_pkg::S_MED1: med_a <= {1'b0, srt_rd};
      bte_pkg::S_MED2: m2 <= n[0] ? {med_a[15:0], 1'b0} : med_a + {1'b0, srt_rd};
      bte_pkg::S_TCHK: begin
        dq   <= bte_pkg::TEMPO_NUM + 21'(m2 >> 1);
        drem <= '0;
        it   <= '0;
      end
      bte_pkg::S_DIV: begin
        drem <= dq_bit ? 17'(drs - {1'b0, m2}) : drs[16:0];
        dq   <= dq_next;
        it   <= it + 1'b1;
        if (it == 6'd20) tempo <= dq_next[12:0];
      end
      bte_pkg::S_C2: s2 <= prod[S2W-1:0];
      bte_pkg::S_C3: begin
        crem <= RW'(v);
        quo  <= '0;
        it   <= '0;
      end
      bte_pkg::S_CDIV: begin
        crem <= (crs >= RW'(s2)) ? crs - RW'(s2) : crs;
        quo  <= quo_next;
        it   <= it + 1'b1;
        if (it == 6'd33) begin
          sx   <= quo_next[31:0];
          sr   <= '0;
          sbit <= 32'h4000_0000;
          it   <= '0;
        end
      end
      bte_pkg::S_SQRT: begin
        sx   <= sx_next;
        sr   <= sr_next;
        sbit <= sbit >> 2;
        it   <= it + 1'b1;
        if (it == 6'd15) conf <= bte_pkg::ONE_Q16 - sr_next[16:0];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result beat
  bte_pkg::status_t status;
  always_comb begin
    if (low_sig) status = bte_pkg::ST_LOWSIG;
    else if (tempo != '0 && conf >= conf_floor) status = bte_pkg::ST_DETECT;
    else if (tempo != '0) status = bte_pkg::ST_LOWCONF;
    else status = bte_pkg::ST_NOBEATS;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'b0, beat_r, status, conf, tempo};
    end
  end

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(HISTORY_DEPTH)) else $error("beat count past history depth");

  a_n_bound: assert property (@(posedge clk) disable iff (rst)
    (state != bte_pkg::S_IDLE && state != bte_pkg::S_ENV_A) |-> ({1'b0, n} < cnt || n == '0))
    else $error("more intervals than beats");

  a_lowsig: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[31:30] == bte_pkg::ST_LOWSIG) |->
      (m_axis_tdata[29:0] == '0 && !m_axis_tdata[32]))
    else $error("low-signal beat carries data");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[29:13] <= bte_pkg::ONE_Q16)
    else $error("confidence above one");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready) else $error("frame taken while busy");

endmodule
